// ===== sv/bvrtc_pkg.sv =====
// shared types and constants of the box versus rectangle table collision block
package bvrtc_pkg;

    localparam int COORD_BITS    = 11;
    localparam int SIZE_BITS     = 10;
    localparam int KIND_BITS     = 4;
    localparam int IDX_BITS      = 4;
    localparam int CFG_BITS      = 10;
    localparam int CNT_BITS      = 5;
    localparam int BOX_BITS      = COORD_BITS + 3;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    typedef enum logic [1:0] {
        REQ_WRITE_OBSTACLE,
        REQ_WRITE_TRIGGER,
        REQ_POSITION_QUERY,
        REQ_KIND_QUERY
    } req_type_t;

    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT,
        CFG_BOX_OFFSET_X,
        CFG_BOX_OFFSET_Y,
        CFG_BOX_WIDTH,
        CFG_BOX_HEIGHT,
        CFG_OBSTACLE_COUNT,
        CFG_TRIGGER_COUNT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [SIZE_BITS-1:0]  w;
        logic        [SIZE_BITS-1:0]  h;
    } rect_t;

    typedef struct packed {
        rect_t                rect;
        logic [KIND_BITS-1:0] kind;
    } trig_t;

    typedef struct packed {
        logic signed [BOX_BITS-1:0] left;
        logic signed [BOX_BITS-1:0] top;
        logic signed [BOX_BITS-1:0] right;
        logic signed [BOX_BITS-1:0] bottom;
    } box_t;

endpackage

// ===== sv/bvrtc_if.sv =====
// request and result channel interfaces
interface bvrtc_req_if;
    import bvrtc_pkg::*;

    logic                         valid;
    logic                         ready;
    req_type_t                    req_type;
    logic        [IDX_BITS-1:0]   entry_index;
    logic signed [COORD_BITS-1:0] rect_x;
    logic signed [COORD_BITS-1:0] rect_y;
    logic        [SIZE_BITS-1:0]  rect_w;
    logic        [SIZE_BITS-1:0]  rect_h;
    logic        [KIND_BITS-1:0]  area_kind;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;

    modport source (
        output valid, req_type, entry_index, rect_x, rect_y, rect_w, rect_h,
               area_kind, pos_x, pos_y,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, rect_x, rect_y, rect_w, rect_h,
               area_kind, pos_x, pos_y,
        output ready
    );
endinterface

interface bvrtc_rsp_if;
    import bvrtc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 collides;
    logic                 trigger_found;
    logic [IDX_BITS-1:0]  trigger_slot;
    logic [KIND_BITS-1:0] trigger_kind_out;

    modport source (
        output valid, collides, trigger_found, trigger_slot, trigger_kind_out,
        input  ready
    );

    modport sink (
        input  valid, collides, trigger_found, trigger_slot, trigger_kind_out,
        output ready
    );
endinterface

// ===== sv/bvrtc_overlap.sv =====
// strict axis-aligned overlap test of the collision box against one rectangle
module bvrtc_overlap (
    input  bvrtc_pkg::box_t  box,
    input  bvrtc_pkg::rect_t rect,
    output logic             hit
);
    import bvrtc_pkg::*;

    logic signed [BOX_BITS-1:0] r_left;
    logic signed [BOX_BITS-1:0] r_top;
    logic signed [BOX_BITS-1:0] r_right;
    logic signed [BOX_BITS-1:0] r_bottom;

    always_comb
    begin
        r_left   = $signed({{(BOX_BITS-COORD_BITS){rect.x[COORD_BITS-1]}}, rect.x});
        r_top    = $signed({{(BOX_BITS-COORD_BITS){rect.y[COORD_BITS-1]}}, rect.y});
        r_right  = r_left + $signed({{(BOX_BITS-SIZE_BITS){1'b0}}, rect.w});
        r_bottom = r_top + $signed({{(BOX_BITS-SIZE_BITS){1'b0}}, rect.h});
        hit = (box.left < r_right) && (box.right > r_left) &&
              (box.top < r_bottom) && (box.bottom > r_top);
    end

endmodule

// ===== sv/box_vs_rect_table_collision.sv =====
// top level: rectangle tables in memory, query scan, config registers
//
// usage: requests enter on req, one result per request leaves on rsp
// (valid/ready, a request moves when both are high). a request writes an
// obstacle or trigger entry, asks for a position test of the collision box,
// or asks for the lowest trigger of a given kind. configuration goes through
// the apb port; the user must write it only while no request is in flight,
// which the block itself leaves to the user. pready is tied high.
// a write goes from idle to the finish state, which loads its result into
// the output register. a query walks both tables together, one entry of each
// per cycle through a synchronous memory read, over the larger of the active
// obstacle and trigger counts (kind queries use only the trigger count), then
// loads its result in the finish state. one request is worked on at a time.
// the result sits in an output register; a new request is accepted while it
// waits, and a finished result stalls in the block until rsp is ready.
// reset restores the register defaults; table contents are undefined until
// written and need no clearing.
module box_vs_rect_table_collision #(
    parameter int MAX_OBSTACLES = 16,
    parameter int MAX_TRIGGERS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    bvrtc_req_if.sink                              req,
    bvrtc_rsp_if.source                            rsp,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bvrtc_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [bvrtc_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [bvrtc_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                   pready
);
    import bvrtc_pkg::*;

    localparam int OBS_AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int TRG_AW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
    localparam int MAX_D  = (MAX_OBSTACLES > MAX_TRIGGERS) ? MAX_OBSTACLES : MAX_TRIGGERS;
    localparam int CNTW   = $clog2(MAX_D + 1);

    // configuration registers
    logic [CFG_BITS-1:0] cfg_screen_width_reg;
    logic [CFG_BITS-1:0] cfg_screen_height_reg;
    logic [CFG_BITS-1:0] cfg_box_offset_x_reg;
    logic [CFG_BITS-1:0] cfg_box_offset_y_reg;
    logic [CFG_BITS-1:0] cfg_box_width_reg;
    logic [CFG_BITS-1:0] cfg_box_height_reg;
    logic [CNT_BITS-1:0] cfg_obstacle_count_reg;
    logic [CNT_BITS-1:0] cfg_trigger_count_reg;

    cfg_reg_t cfg_sel;
    logic     cfg_wr;

    // control
    state_t state_reg;
    state_t state_next;

    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] lim_obs_reg;
    logic [CNTW-1:0] lim_trg_reg;
    logic [CNTW-1:0] lim_obs_next;
    logic [CNTW-1:0] lim_trg_next;
    logic            is_pos_reg;
    logic            is_kind_reg;
    logic [KIND_BITS-1:0] kind_reg;
    box_t            box_reg;
    box_t            box_next;

    logic accept;
    logic is_write;
    logic issue_obs;
    logic issue_trg;
    logic out_load;

    // memories
    rect_t obs_mem [MAX_OBSTACLES];
    trig_t trg_mem [MAX_TRIGGERS];

    logic  obs_wr;
    logic  trg_wr;
    rect_t wr_rect;
    rect_t obs_data_reg;
    trig_t trg_data_reg;
    logic  obs_rd_v_reg;
    logic  trg_rd_v_reg;
    logic [TRG_AW-1:0] rd_idx_reg;

    // scan accumulators
    logic                 coll_reg;
    logic                 found_reg;
    logic [TRG_AW-1:0]    slot_reg;
    logic [KIND_BITS-1:0] kout_reg;

    logic obs_hit;
    logic trg_hit;
    logic trg_match;
    logic offscreen;

    // result register
    logic                 out_valid_reg;
    logic                 out_collides_reg;
    logic                 out_found_reg;
    logic [IDX_BITS-1:0]  out_slot_reg;
    logic [KIND_BITS-1:0] out_kind_reg;

    // apb port
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[APB_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_screen_width_reg   <= CFG_BITS'(320);
            cfg_screen_height_reg  <= CFG_BITS'(240);
            cfg_box_offset_x_reg   <= '0;
            cfg_box_offset_y_reg   <= '0;
            cfg_box_width_reg      <= CFG_BITS'(16);
            cfg_box_height_reg     <= CFG_BITS'(16);
            cfg_obstacle_count_reg <= '0;
            cfg_trigger_count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                CFG_SCREEN_WIDTH:   cfg_screen_width_reg   <= pwdata[CFG_BITS-1:0];
                CFG_SCREEN_HEIGHT:  cfg_screen_height_reg  <= pwdata[CFG_BITS-1:0];
                CFG_BOX_OFFSET_X:   cfg_box_offset_x_reg   <= pwdata[CFG_BITS-1:0];
                CFG_BOX_OFFSET_Y:   cfg_box_offset_y_reg   <= pwdata[CFG_BITS-1:0];
                CFG_BOX_WIDTH:      cfg_box_width_reg      <= pwdata[CFG_BITS-1:0];
                CFG_BOX_HEIGHT:     cfg_box_height_reg     <= pwdata[CFG_BITS-1:0];
                CFG_OBSTACLE_COUNT: cfg_obstacle_count_reg <= pwdata[CNT_BITS-1:0];
                CFG_TRIGGER_COUNT:  cfg_trigger_count_reg  <= pwdata[CNT_BITS-1:0];
                default:            cfg_screen_width_reg   <= cfg_screen_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            CFG_SCREEN_WIDTH:   prdata = APB_DATA_BITS'(cfg_screen_width_reg);
            CFG_SCREEN_HEIGHT:  prdata = APB_DATA_BITS'(cfg_screen_height_reg);
            CFG_BOX_OFFSET_X:   prdata = APB_DATA_BITS'(cfg_box_offset_x_reg);
            CFG_BOX_OFFSET_Y:   prdata = APB_DATA_BITS'(cfg_box_offset_y_reg);
            CFG_BOX_WIDTH:      prdata = APB_DATA_BITS'(cfg_box_width_reg);
            CFG_BOX_HEIGHT:     prdata = APB_DATA_BITS'(cfg_box_height_reg);
            CFG_OBSTACLE_COUNT: prdata = APB_DATA_BITS'(cfg_obstacle_count_reg);
            CFG_TRIGGER_COUNT:  prdata = APB_DATA_BITS'(cfg_trigger_count_reg);
            default:            prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_write ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue_obs && !issue_trg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        accept    = req.valid && (state_reg == ST_IDLE);
        is_write  = (req.req_type == REQ_WRITE_OBSTACLE) ||
                    (req.req_type == REQ_WRITE_TRIGGER);
        obs_wr    = accept && (req.req_type == REQ_WRITE_OBSTACLE) &&
                    (int'(req.entry_index) < MAX_OBSTACLES);
        trg_wr    = accept && (req.req_type == REQ_WRITE_TRIGGER) &&
                    (int'(req.entry_index) < MAX_TRIGGERS);
        issue_obs = (state_reg == ST_SCAN) && (cnt_reg < lim_obs_reg);
        issue_trg = (state_reg == ST_SCAN) && (cnt_reg < lim_trg_reg);
        out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request setup: box placement and scan limits
    always_comb
    begin
        box_next.left  = $signed({{(BOX_BITS-COORD_BITS){req.pos_x[COORD_BITS-1]}}, req.pos_x}) +
                         $signed({{(BOX_BITS-CFG_BITS){cfg_box_offset_x_reg[CFG_BITS-1]}},
                                  cfg_box_offset_x_reg});
        box_next.top   = $signed({{(BOX_BITS-COORD_BITS){req.pos_y[COORD_BITS-1]}}, req.pos_y}) +
                         $signed({{(BOX_BITS-CFG_BITS){cfg_box_offset_y_reg[CFG_BITS-1]}},
                                  cfg_box_offset_y_reg});
        box_next.right  = box_next.left +
                          $signed({{(BOX_BITS-CFG_BITS){1'b0}}, cfg_box_width_reg});
        box_next.bottom = box_next.top +
                          $signed({{(BOX_BITS-CFG_BITS){1'b0}}, cfg_box_height_reg});

        lim_obs_next = (int'(cfg_obstacle_count_reg) > MAX_OBSTACLES) ?
                       CNTW'(MAX_OBSTACLES) : CNTW'(cfg_obstacle_count_reg);
        lim_trg_next = (int'(cfg_trigger_count_reg) > MAX_TRIGGERS) ?
                       CNTW'(MAX_TRIGGERS) : CNTW'(cfg_trigger_count_reg);
        if (req.req_type != REQ_POSITION_QUERY)
        begin
            lim_obs_next = '0;
        end
        if (is_write)
        begin
            lim_trg_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            lim_obs_reg  <= '0;
            lim_trg_reg  <= '0;
            is_pos_reg   <= 1'b0;
            is_kind_reg  <= 1'b0;
            obs_rd_v_reg <= 1'b0;
            trg_rd_v_reg <= 1'b0;
            coll_reg     <= 1'b0;
            found_reg    <= 1'b0;
            slot_reg     <= '0;
            kout_reg     <= '0;
        end
        else
        begin
            obs_rd_v_reg <= issue_obs;
            trg_rd_v_reg <= issue_trg;
            if (accept)
            begin
                cnt_reg     <= '0;
                lim_obs_reg <= lim_obs_next;
                lim_trg_reg <= lim_trg_next;
                is_pos_reg  <= (req.req_type == REQ_POSITION_QUERY);
                is_kind_reg <= (req.req_type == REQ_KIND_QUERY);
                coll_reg    <= 1'b0;
                found_reg   <= 1'b0;
                slot_reg    <= '0;
                kout_reg    <= '0;
            end
            else
            begin
                if (issue_obs || issue_trg)
                begin
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
                if (obs_rd_v_reg && obs_hit)
                begin
                    coll_reg <= 1'b1;
                end
                if (trg_rd_v_reg && !found_reg && trg_match)
                begin
                    found_reg <= 1'b1;
                    slot_reg  <= rd_idx_reg;
                    kout_reg  <= trg_data_reg.kind;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_reg  <= box_next;
            kind_reg <= req.area_kind;
        end
        rd_idx_reg <= cnt_reg[TRG_AW-1:0];
    end

    // table memories
    assign wr_rect = '{x: req.rect_x, y: req.rect_y, w: req.rect_w, h: req.rect_h};

    always_ff @(posedge clk)
    begin
        if (obs_wr)
        begin
            obs_mem[OBS_AW'(req.entry_index)] <= wr_rect;
        end
        obs_data_reg <= obs_mem[cnt_reg[OBS_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (trg_wr)
        begin
            trg_mem[TRG_AW'(req.entry_index)] <= '{rect: wr_rect, kind: req.area_kind};
        end
        trg_data_reg <= trg_mem[cnt_reg[TRG_AW-1:0]];
    end

    // entry tests
    bvrtc_overlap u_obs_overlap (
        .box  (box_reg),
        .rect (obs_data_reg),
        .hit  (obs_hit)
    );

    bvrtc_overlap u_trg_overlap (
        .box  (box_reg),
        .rect (trg_data_reg.rect),
        .hit  (trg_hit)
    );

    assign trg_match = is_kind_reg ? (trg_data_reg.kind == kind_reg) : trg_hit;

    assign offscreen = (box_reg.left < 0) || (box_reg.top < 0) ||
                       (box_reg.right >
                        $signed({{(BOX_BITS-CFG_BITS){1'b0}}, cfg_screen_width_reg})) ||
                       (box_reg.bottom >
                        $signed({{(BOX_BITS-CFG_BITS){1'b0}}, cfg_screen_height_reg}));

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_collides_reg <= coll_reg || (is_pos_reg && offscreen);
            out_found_reg    <= found_reg;
            out_slot_reg     <= IDX_BITS'(slot_reg);
            out_kind_reg     <= kout_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.collides         = out_collides_reg;
    assign rsp.trigger_found    = out_found_reg;
    assign rsp.trigger_slot     = out_slot_reg;
    assign rsp.trigger_kind_out = out_kind_reg;

endmodule

// ===== tb/sv/box_vs_rect_table_collision_test.sv =====
// testbench for the box versus rectangle table collision block
module box_vs_rect_table_collision_test;
    import bvrtc_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 195;
    localparam int PHASES      = 7;

    typedef struct {
        req_type_t                    op;
        logic        [IDX_BITS-1:0]   slot;
        rect_t                        rect;
        logic        [KIND_BITS-1:0]  kind;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
    } request_t;

    typedef struct packed {
        logic                 collides;
        logic                 found;
        logic [IDX_BITS-1:0]  slot;
        logic [KIND_BITS-1:0] kind;
    } outcome_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    bvrtc_req_if req_if();
    bvrtc_rsp_if rsp_if();

    box_vs_rect_table_collision uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic        [SIZE_BITS-1:0] scr_width;
    logic        [SIZE_BITS-1:0] scr_height;
    logic signed [CFG_BITS-1:0]  box_off_x;
    logic signed [CFG_BITS-1:0]  box_off_y;
    logic        [SIZE_BITS-1:0] box_w;
    logic        [SIZE_BITS-1:0] box_h;
    logic        [CNT_BITS-1:0]  obstacle_cnt;
    logic        [CNT_BITS-1:0]  trigger_cnt;

    rect_t                  obstacle_mem [TABLE_DEPTH];
    trig_t                  trigger_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] obstacle_written;
    logic [TABLE_DEPTH-1:0] trigger_written;

    request_t pending_requests [$];
    outcome_t expected_outcomes [$];
    request_t current_req;
    outcome_t want_outcome;
    outcome_t got_outcome;

    bit req_fire = 1'b0;
    bit idle_on  = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int writes_seen = 0;
    int position_seen = 0;
    int kind_seen = 0;
    int settings_applied = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit box_hits(int ax, int ay, int aw, int ah, rect_t r);
        int rx, ry, rw, rh;
        rx = $signed(r.x);
        ry = $signed(r.y);
        rw = r.w;
        rh = r.h;
        return (ax < rx + rw) && (ax + aw > rx) && (ay < ry + rh) && (ay + ah > ry);
    endfunction

    function automatic int active_entries(logic [CNT_BITS-1:0] cnt);
        return (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
    endfunction

    function automatic int leading_ones(logic [TABLE_DEPTH-1:0] flags);
        int n;
        n = 0;
        while (n < TABLE_DEPTH && flags[n])
            n++;
        return n;
    endfunction

    function automatic outcome_t predict_outcome(request_t r);
        outcome_t o;
        int cx, cy, bw, bh, sw, sh;
        o = '0;
        case (r.op)
            REQ_WRITE_OBSTACLE:
            begin
                obstacle_mem[r.slot] = r.rect;
                obstacle_written[r.slot] = 1'b1;
            end
            REQ_WRITE_TRIGGER:
            begin
                trigger_mem[r.slot].rect = r.rect;
                trigger_mem[r.slot].kind = r.kind;
                trigger_written[r.slot] = 1'b1;
            end
            REQ_POSITION_QUERY:
            begin
                cx = r.pos_x;
                cy = r.pos_y;
                cx = cx + box_off_x;
                cy = cy + box_off_y;
                bw = box_w;
                bh = box_h;
                sw = scr_width;
                sh = scr_height;
                for (int i = 0; i < active_entries(obstacle_cnt); i++)
                    if (!o.collides && box_hits(cx, cy, bw, bh, obstacle_mem[i]))
                        o.collides = 1'b1;
                if (cx < 0 || cy < 0 || cx + bw > sw || cy + bh > sh)
                    o.collides = 1'b1;
                for (int i = 0; i < active_entries(trigger_cnt); i++)
                    if (!o.found && box_hits(cx, cy, bw, bh, trigger_mem[i].rect))
                    begin
                        o.found = 1'b1;
                        o.slot  = IDX_BITS'(i);
                        o.kind  = trigger_mem[i].kind;
                    end
            end
            default:
            begin
                for (int i = 0; i < active_entries(trigger_cnt); i++)
                    if (!o.found && trigger_mem[i].kind == r.kind)
                    begin
                        o.found = 1'b1;
                        o.slot  = IDX_BITS'(i);
                        o.kind  = trigger_mem[i].kind;
                    end
            end
        endcase
        return o;
    endfunction

    function automatic request_t make_write(req_type_t op, int slot, int x, int y, int w,
                                            int h, int kind);
        request_t r;
        r.op     = op;
        r.slot   = IDX_BITS'(slot);
        r.rect.x = COORD_BITS'(x);
        r.rect.y = COORD_BITS'(y);
        r.rect.w = SIZE_BITS'(w);
        r.rect.h = SIZE_BITS'(h);
        r.kind   = KIND_BITS'(kind);
        r.pos_x  = '0;
        r.pos_y  = '0;
        return r;
    endfunction

    function automatic request_t make_position_query(int x, int y);
        request_t r;
        r = make_write(REQ_POSITION_QUERY, 0, 0, 0, 0, 0, 0);
        r.pos_x = COORD_BITS'(x);
        r.pos_y = COORD_BITS'(y);
        return r;
    endfunction

    function automatic request_t make_kind_query(int kind);
        request_t r;
        r = make_write(REQ_KIND_QUERY, 0, 0, 0, 0, 0, kind);
        return r;
    endfunction

    // mostly in-play rectangles and positions near stored entries, some full-range noise
    function automatic request_t random_request();
        request_t r;
        rect_t    anchor;
        int       pick, ax, ay, ox, oy, anchor_slot;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            r.op = REQ_WRITE_OBSTACLE;
        else if (pick < 24)
            r.op = REQ_WRITE_TRIGGER;
        else if (pick < 82)
            r.op = REQ_POSITION_QUERY;
        else
            r.op = REQ_KIND_QUERY;
        r.slot = IDX_BITS'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            r.rect.x = COORD_BITS'($urandom_range(0, 964) - 64);
            r.rect.y = COORD_BITS'($urandom_range(0, 704) - 64);
            r.rect.w = SIZE_BITS'($urandom_range(0, 160));
            r.rect.h = SIZE_BITS'($urandom_range(0, 160));
        end
        else
        begin
            r.rect.x = COORD_BITS'($urandom);
            r.rect.y = COORD_BITS'($urandom);
            r.rect.w = SIZE_BITS'($urandom);
            r.rect.h = SIZE_BITS'($urandom);
        end
        r.kind = ($urandom_range(0, 9) < 7) ? KIND_BITS'($urandom_range(0, 3))
                                            : KIND_BITS'($urandom);
        ox = box_off_x;
        oy = box_off_y;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                anchor_slot = $urandom_range(0, TABLE_DEPTH - 1);
                anchor = $urandom_range(0, 1) ? obstacle_mem[anchor_slot]
                                              : trigger_mem[anchor_slot].rect;
                ax = $signed(anchor.x);
                ay = $signed(anchor.y);
                r.pos_x = COORD_BITS'(ax - ox + int'($urandom_range(0, 48)) - 32);
                r.pos_y = COORD_BITS'(ay - oy + int'($urandom_range(0, 48)) - 32);
            end
            4, 5, 6:
            begin
                r.pos_x = COORD_BITS'(int'($urandom_range(0, scr_width)) - ox);
                r.pos_y = COORD_BITS'(int'($urandom_range(0, scr_height)) - oy);
            end
            default:
            begin
                r.pos_x = COORD_BITS'($urandom);
                r.pos_y = COORD_BITS'($urandom);
            end
        endcase
        return r;
    endfunction

    task automatic write_reg(cfg_reg_t which, int value);
        logic [APB_DATA_BITS-1:0] data;
        if (which == CFG_OBSTACLE_COUNT || which == CFG_TRIGGER_COUNT)
            data = value & 32'h1f;
        else
            data = value & 32'h3ff;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            CFG_SCREEN_WIDTH:   scr_width    = data[SIZE_BITS-1:0];
            CFG_SCREEN_HEIGHT:  scr_height   = data[SIZE_BITS-1:0];
            CFG_BOX_OFFSET_X:   box_off_x    = data[CFG_BITS-1:0];
            CFG_BOX_OFFSET_Y:   box_off_y    = data[CFG_BITS-1:0];
            CFG_BOX_WIDTH:      box_w        = data[SIZE_BITS-1:0];
            CFG_BOX_HEIGHT:     box_h        = data[SIZE_BITS-1:0];
            CFG_OBSTACLE_COUNT: obstacle_cnt = data[CNT_BITS-1:0];
            default:            trigger_cnt  = data[CNT_BITS-1:0];
        endcase
    endtask

    // active counts never reach past the written entries
    task automatic configure(int sw, int sh, int ox, int oy, int bw, int bh, int oc, int tc);
        int obs_ready, trig_ready;
        obs_ready  = leading_ones(obstacle_written);
        trig_ready = leading_ones(trigger_written);
        if (obs_ready < TABLE_DEPTH && oc > obs_ready)
            oc = obs_ready;
        if (trig_ready < TABLE_DEPTH && tc > trig_ready)
            tc = trig_ready;
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
        write_reg(CFG_BOX_OFFSET_X, ox);
        write_reg(CFG_BOX_OFFSET_Y, oy);
        write_reg(CFG_BOX_WIDTH, bw);
        write_reg(CFG_BOX_HEIGHT, bh);
        write_reg(CFG_OBSTACLE_COUNT, oc);
        write_reg(CFG_TRIGGER_COUNT, tc);
        settings_applied++;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_if.valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // request driver
    always @(posedge clk)
    begin
        req_fire = rst_n && req_if.valid && req_if.ready;
        if (req_fire)
        begin
            expected_outcomes.push_back(predict_outcome(current_req));
            case (current_req.op)
                REQ_POSITION_QUERY: position_seen++;
                REQ_KIND_QUERY:     kind_seen++;
                default:            writes_seen++;
            endcase
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req_if.valid || req_fire))
        begin
            if (send_gap > 0)
            begin
                req_if.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_requests.size() != 0)
            begin
                current_req = pending_requests.pop_front();
                req_if.req_type    <= current_req.op;
                req_if.entry_index <= current_req.slot;
                req_if.rect_x      <= current_req.rect.x;
                req_if.rect_y      <= current_req.rect.y;
                req_if.rect_w      <= current_req.rect.w;
                req_if.rect_h      <= current_req.rect.h;
                req_if.area_kind   <= current_req.kind;
                req_if.pos_x       <= current_req.pos_x;
                req_if.pos_y       <= current_req.pos_y;
                req_if.valid       <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // result monitor
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_outcome = {rsp_if.collides, rsp_if.trigger_found, rsp_if.trigger_slot,
                           rsp_if.trigger_kind_out};
            if (expected_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with nothing expected: collides=%0b found=%0b slot=%0d kind=%0d",
                             got_outcome.collides, got_outcome.found, got_outcome.slot,
                             got_outcome.kind);
            end
            else
            begin
                want_outcome = expected_outcomes.pop_front();
                results_checked++;
                if (got_outcome !== want_outcome)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch on result %0d: expected collides=%0b found=%0b ",
                                  "slot=%0d kind=%0d, got collides=%0b found=%0b slot=%0d kind=%0d"},
                                 results_checked, want_outcome.collides, want_outcome.found,
                                 want_outcome.slot, want_outcome.kind, got_outcome.collides,
                                 got_outcome.found, got_outcome.slot, got_outcome.kind);
                end
            end
        end
    end

    initial
    begin
        int       order [2*TABLE_DEPTH];
        int       j, tmp;
        request_t r;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_WRITE_OBSTACLE;
        req_if.entry_index = '0;
        req_if.rect_x      = '0;
        req_if.rect_y      = '0;
        req_if.rect_w      = '0;
        req_if.rect_h      = '0;
        req_if.area_kind   = '0;
        req_if.pos_x       = '0;
        req_if.pos_y       = '0;
        rsp_if.ready       = 1'b0;
        scr_width    = 10'd320;
        scr_height   = 10'd240;
        box_off_x    = '0;
        box_off_y    = '0;
        box_w        = 10'd16;
        box_h        = 10'd16;
        obstacle_cnt = '0;
        trigger_cnt  = '0;
        obstacle_written = '0;
        trigger_written  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            obstacle_mem[i] = '0;
            trigger_mem[i]  = '0;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, empty tables: screen edges only
        idle_on = 1'b1;
        pending_requests.push_back(make_position_query(0, 0));
        pending_requests.push_back(make_position_query(-1, 0));
        pending_requests.push_back(make_position_query(0, -1));
        pending_requests.push_back(make_position_query(304, 224));
        pending_requests.push_back(make_position_query(305, 224));
        pending_requests.push_back(make_position_query(304, 225));
        pending_requests.push_back(make_kind_query(0));
        pending_requests.push_back(make_write(REQ_WRITE_OBSTACLE, 0, 100, 100, 20, 20, 7));
        pending_requests.push_back(make_write(REQ_WRITE_OBSTACLE, 1, -1024, -1024, 1023, 1023, 15));
        pending_requests.push_back(make_write(REQ_WRITE_OBSTACLE, 2, 1023, 1023, 0, 0, 0));
        pending_requests.push_back(make_write(REQ_WRITE_TRIGGER, 0, 50, 50, 10, 10, 5));
        pending_requests.push_back(make_write(REQ_WRITE_TRIGGER, 1, 100, 100, 20, 20, 5));
        pending_requests.push_back(make_write(REQ_WRITE_TRIGGER, 2, 0, 0, 1023, 1023, 15));
        pending_requests.push_back(make_write(REQ_WRITE_TRIGGER, 3, 1023, -1024, 0, 1023, 0));
        wait_idle();
        configure(320, 240, 0, 0, 16, 16, 3, 4);

        // touching edges, lowest trigger wins, kind lookups
        pending_requests.push_back(make_position_query(84, 100));
        pending_requests.push_back(make_position_query(85, 100));
        pending_requests.push_back(make_position_query(45, 45));
        pending_requests.push_back(make_position_query(1023, 1023));
        pending_requests.push_back(make_position_query(-1024, -1024));
        pending_requests.push_back(make_kind_query(5));
        pending_requests.push_back(make_kind_query(15));
        pending_requests.push_back(make_kind_query(0));
        pending_requests.push_back(make_kind_query(9));
        wait_idle();

        // fill every slot of both tables in random order
        for (int i = 0; i < 2*TABLE_DEPTH; i++)
            order[i] = i;
        for (int i = 2*TABLE_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 2*TABLE_DEPTH; i++)
        begin
            r = random_request();
            r.op   = (order[i] < TABLE_DEPTH) ? REQ_WRITE_OBSTACLE : REQ_WRITE_TRIGGER;
            r.slot = IDX_BITS'(order[i] % TABLE_DEPTH);
            pending_requests.push_back(r);
            pending_requests.push_back(random_request());
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: configure(1023, 1023, 0, 0, 16, 16, 16, 16);
                1: configure(0, 0, -512, 511, 0, 0, 31, 17);
                2: configure(320, 240, 511, -512, 1023, 1023, 0, 16);
                4: configure(640, 480, -8, -8, 24, 32, 8, 16);
                6: configure(320, 240, -4, -4, 16, 16, 16, 16);
                default:
                    configure($urandom_range(0, 1023), $urandom_range(0, 1023),
                              int'($urandom_range(0, 1023)) - 512,
                              int'($urandom_range(0, 1023)) - 512,
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 48),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 48),
                              $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            idle_on = (p != 2 && p != PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_requests.push_back(random_request());
        end

        wait_idle();
        repeat (24) @(posedge clk);
        $display("covered %0d table writes, %0d position queries, %0d kind queries",
                 writes_seen, position_seen, kind_seen);
        $display("%0d results checked under %0d register settings, %0d mismatches",
                 results_checked, settings_applied, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bvrtc_pkg.sv
sv/bvrtc_if.sv
sv/bvrtc_overlap.sv
sv/box_vs_rect_table_collision.sv
tb/sv/box_vs_rect_table_collision_test.sv
